>>> src/cqgp_pkg.sv
// Shared types and constants for the controlled qubit gate pair update unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package cqgp_pkg;

    localparam int QUBIT_COUNT_DEF = 20;
    localparam int AMP_WIDTH_DEF   = 32;

    localparam int GATE_W    = 64;
    localparam int GATE_FRAC = 30;
    localparam int CFG_AW    = 6;
    localparam int CFG_DW    = 64;

    localparam int PAIR_W  = 19;
    localparam int INDEX_W = 20;
    localparam int OUT_W   = 32;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 3;

    localparam logic [2:0] REG_GATE_UL  = 3'd0;
    localparam logic [2:0] REG_GATE_UR  = 3'd1;
    localparam logic [2:0] REG_GATE_LL  = 3'd2;
    localparam logic [2:0] REG_GATE_LR  = 3'd3;
    localparam logic [2:0] REG_TARGET   = 3'd4;
    localparam logic [2:0] REG_CONTROL  = 3'd5;
    localparam logic [2:0] REG_DERIV    = 3'd6;

    localparam logic [GATE_W-1:0] GATE_ONE_RST = 64'h4000_0000_0000_0000;
    localparam logic [5:0]        CTRL_NONE    = 6'h3F;

    typedef enum logic [1:0] {
        ACT_GATE = 2'd0,
        ACT_ZERO = 2'd1,
        ACT_PASS = 2'd2
    } t_action;

    typedef struct packed {
        logic [GATE_W-1:0] gate_ul;
        logic [GATE_W-1:0] gate_ur;
        logic [GATE_W-1:0] gate_ll;
        logic [GATE_W-1:0] gate_lr;
        logic [4:0]        target;
        logic [5:0]        control;
        logic              deriv;
    } t_cfg;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_mac_ld;

endpackage

`default_nettype wire

>>> src/controlled_qubit_gate_pair_update_unit.sv
// Five register stages; one item per cycle while the output is not stalled
// (back-pressure from the output holds every full stage behind it).
// Stages: index and control decode, 32x32 products, rounding, partial sums,
// final sum with saturation and output select into the output register.
// Each stage advances when it is empty or the next one advances.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults: identity gate, target 0, uncontrolled, normal mode.
`default_nettype none

module controlled_qubit_gate_pair_update_unit
    import cqgp_pkg::*;
#(
    parameter int QUBIT_COUNT = QUBIT_COUNT_DEF,
    parameter int AMP_WIDTH   = AMP_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // pair_number[18:0], low_amp_real, low_amp_imag, high_amp_real,
    // high_amp_imag (32 each), zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // low_state_index[19:0], high_state_index, new_low_real, new_low_imag,
    // new_high_real, new_high_imag
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // action_taken[1:0], saturated[2]
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [CFG_DW-1:0]      pwdata,
    output logic      [CFG_DW-1:0]      prdata,
    output logic                        pready
);

    t_cfg                          w_cfg;
    logic [4:0]                    r_v;
    logic [4:0]                    w_rdy;
    logic [QUBIT_COUNT-1:0]        n_lo, n_hi;
    t_action                       n_act;
    logic [QUBIT_COUNT-1:0]        r_lo  [4];
    logic [QUBIT_COUNT-1:0]        r_hi  [4];
    t_action                       r_act [4];
    logic signed [AMP_WIDTH-1:0]   r_amp [4][4];
    t_mac_ld                       w_ld;
    logic signed [AMP_WIDTH-1:0]   w_re0, w_im0, w_re1, w_im1;
    logic                          w_sat0, w_sat1;
    logic [INDEX_W-1:0]            n_o_lo, n_o_hi;
    logic [INDEX_W-1:0]            r_o_lo, r_o_hi;
    logic [OUT_W-1:0]              r_o_amp [4];
    t_action                       r_o_act;
    logic                          r_o_sat;

    cqgp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cqgp_index #(.QUBIT_COUNT(QUBIT_COUNT)) u_index (
        .i_pair_number (i_s_axis_tdata[PAIR_W-1:0]),
        .i_target      (w_cfg.target),
        .i_control     (w_cfg.control),
        .i_deriv       (w_cfg.deriv),
        .o_lo          (n_lo),
        .o_hi          (n_hi),
        .o_action      (n_act)
    );

    always_comb begin
        w_rdy[4] = !r_v[4] || i_m_axis_tready;
        for (int k = 3; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[4];
    assign w_ld.s2 = w_rdy[1];
    assign w_ld.s3 = w_rdy[2];
    assign w_ld.s4 = w_rdy[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < 5; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_lo[0]     <= n_lo;
            r_hi[0]     <= n_hi;
            r_act[0]    <= n_act;
            r_amp[0][0] <= signed'(i_s_axis_tdata[PAIR_W +: AMP_WIDTH]);
            r_amp[0][1] <= signed'(i_s_axis_tdata[PAIR_W + OUT_W +: AMP_WIDTH]);
            r_amp[0][2] <= signed'(i_s_axis_tdata[PAIR_W + 2*OUT_W +: AMP_WIDTH]);
            r_amp[0][3] <= signed'(i_s_axis_tdata[PAIR_W + 3*OUT_W +: AMP_WIDTH]);
        end
        for (int k = 1; k < 4; k++) begin
            if (w_rdy[k]) begin
                r_lo[k]  <= r_lo[k-1];
                r_hi[k]  <= r_hi[k-1];
                r_act[k] <= r_act[k-1];
                r_amp[k] <= r_amp[k-1];
            end
        end
    end

    cqgp_cmac #(.AMP_WIDTH(AMP_WIDTH)) u_mac_low (
        .i_clk (i_clk),
        .i_ld  (w_ld),
        .i_ga  (w_cfg.gate_ul),
        .i_gb  (w_cfg.gate_ur),
        .i_xr  (r_amp[0][0]),
        .i_xi  (r_amp[0][1]),
        .i_yr  (r_amp[0][2]),
        .i_yi  (r_amp[0][3]),
        .o_re  (w_re0),
        .o_im  (w_im0),
        .o_sat (w_sat0)
    );

    cqgp_cmac #(.AMP_WIDTH(AMP_WIDTH)) u_mac_high (
        .i_clk (i_clk),
        .i_ld  (w_ld),
        .i_ga  (w_cfg.gate_ll),
        .i_gb  (w_cfg.gate_lr),
        .i_xr  (r_amp[0][0]),
        .i_xi  (r_amp[0][1]),
        .i_yr  (r_amp[0][2]),
        .i_yi  (r_amp[0][3]),
        .o_re  (w_re1),
        .o_im  (w_im1),
        .o_sat (w_sat1)
    );

    if (QUBIT_COUNT >= INDEX_W) begin : g_idx_trunc
        assign n_o_lo = r_lo[3][INDEX_W-1:0];
        assign n_o_hi = r_hi[3][INDEX_W-1:0];
    end else begin : g_idx_ext
        assign n_o_lo = INDEX_W'(r_lo[3]);
        assign n_o_hi = INDEX_W'(r_hi[3]);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_o_lo  <= n_o_lo;
            r_o_hi  <= n_o_hi;
            r_o_act <= r_act[3];
            case (r_act[3])
                ACT_GATE: begin
                    r_o_amp[0] <= OUT_W'(w_re0);
                    r_o_amp[1] <= OUT_W'(w_im0);
                    r_o_amp[2] <= OUT_W'(w_re1);
                    r_o_amp[3] <= OUT_W'(w_im1);
                    r_o_sat    <= w_sat0 || w_sat1;
                end
                ACT_ZERO: begin
                    for (int k = 0; k < 4; k++) begin
                        r_o_amp[k] <= '0;
                    end
                    r_o_sat <= 1'b0;
                end
                default: begin
                    for (int k = 0; k < 4; k++) begin
                        r_o_amp[k] <= OUT_W'(r_amp[3][k]);
                    end
                    r_o_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_axis_tdata = {r_o_amp[3], r_o_amp[2], r_o_amp[1], r_o_amp[0],
                             r_o_hi, r_o_lo};
    assign o_m_axis_tuser = {r_o_sat, r_o_act};

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_s_axis_tready)
        else $error("input stalled with empty first stage");

    a_index_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> $countones(r_lo[3] ^ r_hi[3]) == 1)
        else $error("state indices differ in other than one bit");

    a_sat_only_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_o_act != ACT_GATE) |-> !r_o_sat)
        else $error("saturation flagged on a bypassed pair");

    a_zero_amps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_o_act == ACT_ZERO) |->
        (r_o_amp[0] == '0 && r_o_amp[1] == '0 && r_o_amp[2] == '0 && r_o_amp[3] == '0))
        else $error("zeroed pair carries nonzero amplitude");

endmodule

`default_nettype wire

>>> src/cqgp_regs.sv
// APB configuration registers: gate matrix, target, control and mode.
// Depends on cqgp_pkg.
`default_nettype none

module cqgp_regs
    import cqgp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_ul <= GATE_ONE_RST;
            r_cfg.gate_ur <= '0;
            r_cfg.gate_ll <= '0;
            r_cfg.gate_lr <= GATE_ONE_RST;
            r_cfg.target  <= '0;
            r_cfg.control <= CTRL_NONE;
            r_cfg.deriv   <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_GATE_UL: r_cfg.gate_ul <= pwdata;
                REG_GATE_UR: r_cfg.gate_ur <= pwdata;
                REG_GATE_LL: r_cfg.gate_ll <= pwdata;
                REG_GATE_LR: r_cfg.gate_lr <= pwdata;
                REG_TARGET:  r_cfg.target  <= pwdata[4:0];
                REG_CONTROL: r_cfg.control <= pwdata[5:0];
                REG_DERIV:   r_cfg.deriv   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GATE_UL: prdata = r_cfg.gate_ul;
            REG_GATE_UR: prdata = r_cfg.gate_ur;
            REG_GATE_LL: prdata = r_cfg.gate_ll;
            REG_GATE_LR: prdata = r_cfg.gate_lr;
            REG_TARGET:  prdata = CFG_DW'(r_cfg.target);
            REG_CONTROL: prdata = CFG_DW'(r_cfg.control);
            REG_DERIV:   prdata = CFG_DW'(r_cfg.deriv);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/cqgp_index.sv
// State index formation and control decision for one amplitude pair.
// Depends on cqgp_pkg.
`default_nettype none

module cqgp_index
    import cqgp_pkg::*;
#(
    parameter int QUBIT_COUNT = QUBIT_COUNT_DEF
) (
    input  wire logic [PAIR_W-1:0]      i_pair_number,
    input  wire logic [4:0]             i_target,
    input  wire logic [5:0]             i_control,
    input  wire logic                   i_deriv,
    output logic      [QUBIT_COUNT-1:0] o_lo,
    output logic      [QUBIT_COUNT-1:0] o_hi,
    output t_action                     o_action
);

    localparam int TW = (QUBIT_COUNT > 2) ? $clog2(QUBIT_COUNT) : 1;

    logic [QUBIT_COUNT-2:0] w_pn;
    logic [QUBIT_COUNT-1:0] w_pn_ext;
    logic [QUBIT_COUNT-1:0] w_pn_sh;
    logic [TW-1:0]          w_t;
    logic                   w_apply;

    if (QUBIT_COUNT - 1 <= PAIR_W) begin : g_pn_trunc
        assign w_pn = i_pair_number[QUBIT_COUNT-2:0];
    end else begin : g_pn_ext
        assign w_pn = (QUBIT_COUNT-1)'(i_pair_number);
    end

    assign w_pn_ext = {1'b0, w_pn};
    assign w_pn_sh  = {w_pn, 1'b0};
    assign w_t = (int'(i_target) > QUBIT_COUNT - 1) ? TW'(QUBIT_COUNT - 1)
                                                    : TW'(i_target);

    always_comb begin
        for (int i = 0; i < QUBIT_COUNT; i++) begin
            if (i < int'(w_t)) begin
                o_lo[i] = w_pn_ext[i];
            end else if (i == int'(w_t)) begin
                o_lo[i] = 1'b0;
            end else begin
                o_lo[i] = w_pn_sh[i];
            end
        end
    end

    assign o_hi = o_lo | (QUBIT_COUNT'(1) << w_t);

    always_comb begin
        w_apply = 1'b0;
        if (i_control[5]) begin
            w_apply = 1'b1;
        end else begin
            for (int i = 0; i < QUBIT_COUNT; i++) begin
                if (i_control == 6'(i)) begin
                    w_apply = o_lo[i];
                end
            end
        end
    end

    always_comb begin
        if (w_apply) begin
            o_action = ACT_GATE;
        end else if (i_deriv) begin
            o_action = ACT_ZERO;
        end else begin
            o_action = ACT_PASS;
        end
    end

endmodule

`default_nettype wire

>>> src/cqgp_cmac.sv
// One output amplitude ga*x + gb*y: product, rounding and partial-sum
// register stages, then final sum and saturation. Depends on cqgp_pkg.
`default_nettype none

module cqgp_cmac
    import cqgp_pkg::*;
#(
    parameter int AMP_WIDTH = AMP_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire t_mac_ld                     i_ld,
    input  wire logic        [GATE_W-1:0]    i_ga,
    input  wire logic        [GATE_W-1:0]    i_gb,
    input  wire logic signed [AMP_WIDTH-1:0] i_xr,
    input  wire logic signed [AMP_WIDTH-1:0] i_xi,
    input  wire logic signed [AMP_WIDTH-1:0] i_yr,
    input  wire logic signed [AMP_WIDTH-1:0] i_yi,
    output logic signed      [AMP_WIDTH-1:0] o_re,
    output logic signed      [AMP_WIDTH-1:0] o_im,
    output logic                             o_sat
);

    localparam int GW = GATE_W / 2;
    localparam int PW = GW + AMP_WIDTH;
    localparam int RW = PW - GATE_FRAC;
    localparam int SW = RW + 2;

    logic signed [GW-1:0]   w_ar, w_ai, w_br, w_bi;
    logic signed [PW-1:0]   r_prod [8];
    logic signed [RW-1:0]   r_rnd  [8];
    logic signed [RW:0]     r_psum [4];
    logic signed [SW-1:0]   w_sr, w_si;
    logic                   w_sat_r, w_sat_i;

    assign w_ar = signed'(i_ga[GATE_W-1:GW]);
    assign w_ai = signed'(i_ga[GW-1:0]);
    assign w_br = signed'(i_gb[GATE_W-1:GW]);
    assign w_bi = signed'(i_gb[GW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_prod[0] <= w_ar * i_xr;
            r_prod[1] <= w_ai * i_xi;
            r_prod[2] <= w_br * i_yr;
            r_prod[3] <= w_bi * i_yi;
            r_prod[4] <= w_ar * i_xi;
            r_prod[5] <= w_ai * i_xr;
            r_prod[6] <= w_br * i_yi;
            r_prod[7] <= w_bi * i_yr;
        end
    end

    // round to nearest, ties toward +inf: floor((p + half) / 2^frac)
    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            for (int k = 0; k < 8; k++) begin
                r_rnd[k] <= RW'((r_prod[k] + (PW'(1) <<< (GATE_FRAC - 1))) >>> GATE_FRAC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r_psum[0] <= (RW+1)'(r_rnd[0]) - (RW+1)'(r_rnd[1]);
            r_psum[1] <= (RW+1)'(r_rnd[2]) - (RW+1)'(r_rnd[3]);
            r_psum[2] <= (RW+1)'(r_rnd[4]) + (RW+1)'(r_rnd[5]);
            r_psum[3] <= (RW+1)'(r_rnd[6]) + (RW+1)'(r_rnd[7]);
        end
    end

    assign w_sr = SW'(r_psum[0]) + SW'(r_psum[1]);
    assign w_si = SW'(r_psum[2]) + SW'(r_psum[3]);

    // fits when the sign bit and all bits above it agree
    always_comb begin
        w_sat_r = !((&w_sr[SW-1:AMP_WIDTH-1]) || !(|w_sr[SW-1:AMP_WIDTH-1]));
        w_sat_i = !((&w_si[SW-1:AMP_WIDTH-1]) || !(|w_si[SW-1:AMP_WIDTH-1]));
        if (w_sat_r) begin
            o_re = w_sr[SW-1] ? {1'b1, {(AMP_WIDTH-1){1'b0}}}
                              : {1'b0, {(AMP_WIDTH-1){1'b1}}};
        end else begin
            o_re = w_sr[AMP_WIDTH-1:0];
        end
        if (w_sat_i) begin
            o_im = w_si[SW-1] ? {1'b1, {(AMP_WIDTH-1){1'b0}}}
                              : {1'b0, {(AMP_WIDTH-1){1'b1}}};
        end else begin
            o_im = w_si[AMP_WIDTH-1:0];
        end
        o_sat = w_sat_r || w_sat_i;
    end

endmodule

`default_nettype wire

>>> sim/controlled_qubit_gate_pair_update_unit_tb.sv
// Testbench for controlled_qubit_gate_pair_update_unit: streams amplitude pairs through
// the block under many gate settings written over APB and checks every result item
// against a local fixed-point predictor. Depends on cqgp_pkg and the unit itself.
`default_nettype none

module controlled_qubit_gate_pair_update_unit_tb;
    import cqgp_pkg::*;

    localparam int     STUCK_LIMIT   = 3000;
    localparam int     DRAIN_CYCLES  = 8;
    localparam int     PHASE_ITEMS   = 150;
    localparam int     RANDOM_PHASES = 12;
    localparam int     LONG_STALL    = 300;
    localparam longint AMP_HI        = 64'sd2147483647;
    localparam longint AMP_LO        = -64'sd2147483648;

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [31:0]       lo_re;
        logic [31:0]       lo_im;
        logic [31:0]       hi_re;
        logic [31:0]       hi_im;
    } amp_pair_t;

    typedef struct packed {
        logic [INDEX_W-1:0] lo_idx;
        logic [INDEX_W-1:0] hi_idx;
        logic [31:0]        lo_re;
        logic [31:0]        lo_im;
        logic [31:0]        hi_re;
        logic [31:0]        hi_im;
        t_action            act;
        logic               sat;
    } pair_update_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_AW-1:0]      paddr = '0;
    logic [CFG_DW-1:0]      pwdata = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;

    t_cfg         gate_cfg;
    amp_pair_t    pair_feed_q[$];
    pair_update_t expected_updates_q[$];
    amp_pair_t    bus_pair;
    pair_update_t want;
    pair_update_t got;

    int send_idle_pct = 24;
    int recv_idle_pct = 55;
    bit long_stall_req = 1'b0;
    int stall_cycles = 0;
    bit stall_done = 1'b0;
    int stuck_cycles = 0;
    int mismatches = 0;
    int n_gate = 0;
    int n_zero = 0;
    int n_pass = 0;
    int n_sat = 0;
    int n_settings = 0;

    controlled_qubit_gate_pair_update_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Q1.30 product, round half up
    function automatic longint scaled_product(input longint a, input longint b);
        return (a * b + (longint'(1) <<< (GATE_FRAC - 1))) >>> GATE_FRAC;
    endfunction

    function automatic logic [31:0] clip_amp(input longint v, inout logic sat);
        if (v > AMP_HI) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < AMP_LO) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void gate_row(input logic [63:0] ga, input logic [63:0] gb,
                                     input longint xr, input longint xi,
                                     input longint yr, input longint yi,
                                     output logic [31:0] re, output logic [31:0] im,
                                     inout logic sat);
        longint ar, ai, br, bi, sr, si;
        ar = $signed(ga[63:32]);
        ai = $signed(ga[31:0]);
        br = $signed(gb[63:32]);
        bi = $signed(gb[31:0]);
        sr = scaled_product(ar, xr) - scaled_product(ai, xi)
           + scaled_product(br, yr) - scaled_product(bi, yi);
        si = scaled_product(ar, xi) + scaled_product(ai, xr)
           + scaled_product(br, yi) + scaled_product(bi, yr);
        re = clip_amp(sr, sat);
        im = clip_amp(si, sat);
    endfunction

    function automatic pair_update_t predict_pair_update(input amp_pair_t a);
        pair_update_t r;
        int t;
        logic [INDEX_W-1:0] pn, lm;
        logic apply, sat;
        longint xr, xi, yr, yi;
        t = (gate_cfg.target > QUBIT_COUNT_DEF - 1) ? QUBIT_COUNT_DEF - 1
                                                     : int'(gate_cfg.target);
        pn = {1'b0, a.pair};
        lm = (20'd1 << t) - 20'd1;
        r.lo_idx = ((pn & ~lm) << 1) | (pn & lm);
        r.hi_idx = r.lo_idx | (20'd1 << t);
        if (gate_cfg.control[5])
            apply = 1'b1;
        else if (gate_cfg.control >= QUBIT_COUNT_DEF)
            apply = 1'b0;
        else
            apply = r.lo_idx[gate_cfg.control];
        xr = $signed(a.lo_re);
        xi = $signed(a.lo_im);
        yr = $signed(a.hi_re);
        yi = $signed(a.hi_im);
        sat = 1'b0;
        if (apply) begin
            gate_row(gate_cfg.gate_ul, gate_cfg.gate_ur, xr, xi, yr, yi,
                     r.lo_re, r.lo_im, sat);
            gate_row(gate_cfg.gate_ll, gate_cfg.gate_lr, xr, xi, yr, yi,
                     r.hi_re, r.hi_im, sat);
            r.act = ACT_GATE;
        end else if (gate_cfg.deriv) begin
            r.lo_re = '0;
            r.lo_im = '0;
            r.hi_re = '0;
            r.hi_im = '0;
            r.act = ACT_ZERO;
        end else begin
            r.lo_re = a.lo_re;
            r.lo_im = a.lo_im;
            r.hi_re = a.hi_re;
            r.hi_im = a.hi_im;
            r.act = ACT_PASS;
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] random_q130();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3, 4: return $urandom;
            default: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GATE_UL: gate_cfg.gate_ul = value;
            REG_GATE_UR: gate_cfg.gate_ur = value;
            REG_GATE_LL: gate_cfg.gate_ll = value;
            REG_GATE_LR: gate_cfg.gate_lr = value;
            REG_TARGET:  gate_cfg.target  = value[4:0];
            REG_CONTROL: gate_cfg.control = value[5:0];
            REG_DERIV:   gate_cfg.deriv   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] ul, input logic [63:0] ur,
                              input logic [63:0] ll, input logic [63:0] lr,
                              input logic [4:0] tgt, input logic [5:0] ctl,
                              input logic der);
        apb_write(REG_GATE_UL, ul);
        apb_write(REG_GATE_UR, ur);
        apb_write(REG_GATE_LL, ll);
        apb_write(REG_GATE_LR, lr);
        apb_write(REG_TARGET, {59'd0, tgt});
        apb_write(REG_CONTROL, {{58{ctl[5]}}, ctl});
        apb_write(REG_DERIV, {63'd0, der});
        n_settings++;
    endtask

    task automatic randomize_config();
        logic [4:0] tgt;
        logic [5:0] ctl;
        tgt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(19));
        case ($urandom_range(5))
            0: ctl = CTRL_NONE;
            1: ctl = {1'b1, 5'($urandom)};
            2: ctl = {1'b0, tgt};
            3: ctl = 6'($urandom_range(31, 20));
            default: ctl = 6'($urandom_range(19));
        endcase
        set_config({random_q130(), random_q130()}, {random_q130(), random_q130()},
                   {random_q130(), random_q130()}, {random_q130(), random_q130()},
                   tgt, ctl, 1'($urandom));
    endtask

    task automatic push_pair(input logic [PAIR_W-1:0] pair, input logic [31:0] lr,
                             input logic [31:0] li, input logic [31:0] hr,
                             input logic [31:0] hi);
        amp_pair_t p;
        p.pair  = pair;
        p.lo_re = lr;
        p.lo_im = li;
        p.hi_re = hr;
        p.hi_im = hi;
        pair_feed_q.push_back(p);
    endtask

    task automatic push_random_pair();
        logic [PAIR_W-1:0] pair;
        case ($urandom_range(7))
            0: pair = '0;
            1: pair = '1;
            default: pair = PAIR_W'($urandom);
        endcase
        push_pair(pair, random_q130(), random_q130(), random_q130(), random_q130());
    endtask

    task automatic drain_pipeline();
        while (pair_feed_q.size() != 0 || i_s_axis_tvalid || expected_updates_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // driver: prediction is taken at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_updates_q.push_back(predict_pair_update(bus_pair));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pair_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    bus_pair = pair_feed_q.pop_front();
                    i_s_axis_tdata  <= {5'd0, bus_pair.hi_im, bus_pair.hi_re,
                                        bus_pair.lo_im, bus_pair.lo_re, bus_pair.pair};
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (long_stall_req && !stall_done) begin
            i_m_axis_tready <= 1'b0;
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= LONG_STALL - 1)
                stall_done <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_updates_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item, expected none actual %h %h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_updates_q.pop_front();
                got.lo_idx = o_m_axis_tdata[19:0];
                got.hi_idx = o_m_axis_tdata[39:20];
                got.lo_re  = o_m_axis_tdata[71:40];
                got.lo_im  = o_m_axis_tdata[103:72];
                got.hi_re  = o_m_axis_tdata[135:104];
                got.hi_im  = o_m_axis_tdata[167:136];
                got.act    = t_action'(o_m_axis_tuser[1:0]);
                got.sat    = o_m_axis_tuser[2];
                check_field("low_state_index", 32'(want.lo_idx), 32'(got.lo_idx));
                check_field("high_state_index", 32'(want.hi_idx), 32'(got.hi_idx));
                check_field("new_low_real", want.lo_re, got.lo_re);
                check_field("new_low_imag", want.lo_im, got.lo_im);
                check_field("new_high_real", want.hi_re, got.hi_re);
                check_field("new_high_imag", want.hi_im, got.hi_im);
                check_field("action_taken", 32'(want.act), 32'(got.act));
                check_field("saturated", 32'(want.sat), 32'(got.sat));
                case (want.act)
                    ACT_GATE: n_gate++;
                    ACT_ZERO: n_zero++;
                    default:  n_pass++;
                endcase
                if (want.sat)
                    n_sat++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int ph;
        gate_cfg.gate_ul = GATE_ONE_RST;
        gate_cfg.gate_ur = '0;
        gate_cfg.gate_ll = '0;
        gate_cfg.gate_lr = GATE_ONE_RST;
        gate_cfg.target  = '0;
        gate_cfg.control = CTRL_NONE;
        gate_cfg.deriv   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: identity, uncontrolled
        push_pair(19'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        push_pair(19'h7FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(19'h2AAAA, 32'h4000_0000, 32'hC000_0000, 32'h1234_5678, 32'h8765_4321);
        drain_pipeline();

        // largest gate, target beyond range, negative control: saturation
        set_config({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                   {2{32'h7FFF_FFFF}}, 5'd31, 6'h3B, 1'b0);
        push_pair(19'h7FFFF, {4{8'hFF}} >> 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pair(19'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_pair(19'h55555, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        drain_pipeline();

        // control equals target, derivative mode: zeroed
        set_config({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                   {2{32'h8000_0000}}, 5'd19, 6'd19, 1'b1);
        push_pair(19'h7FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1111_1111, 32'hEEEE_EEEE);
        push_pair(19'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1);
        drain_pipeline();

        // control out of range, normal mode: passed
        set_config({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                   {2{32'h8000_0000}}, 5'd0, 6'd25, 1'b0);
        push_pair(19'h7FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        push_pair(19'h12345, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        drain_pipeline();

        // control below target, derivative mode: applied or zeroed by pair bit 3
        set_config({32'h2D41_3CCD, 32'h0}, {32'hD2BE_C333, 32'h0}, {32'h2D41_3CCD, 32'h0},
                   {32'h2D41_3CCD, 32'h0}, 5'd5, 6'd3, 1'b1);
        push_pair(19'h00008, 32'h4000_0000, 32'h0, 32'h0, 32'h4000_0000);
        push_pair(19'h00000, 32'h4000_0000, 32'h0, 32'h0, 32'h4000_0000);
        push_pair(19'h7FFF7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_pair(19'h7FFFF, 32'hC000_0000, 32'h3FFF_FFFF, 32'h2000_0001, 32'hE000_0000);
        drain_pipeline();

        // complex entries, control above target, normal mode
        set_config({32'h0, 32'h4000_0000}, {32'hC000_0000, 32'h0}, 64'h0,
                   {32'h0, 32'hC000_0000}, 5'd2, 6'd10, 1'b0);
        push_pair(19'h00200, 32'h2000_0000, 32'hE000_0000, 32'h0000_0003, 32'hFFFF_FFFD);
        push_pair(19'h001FF, 32'h2000_0000, 32'hE000_0000, 32'h0000_0003, 32'hFFFF_FFFD);
        push_random_pair();
        push_random_pair();
        drain_pipeline();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 24;
            end else if (ph == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_stall_req = 1'b1;
            end
            randomize_config();
            repeat (PHASE_ITEMS) push_random_pair();
            drain_pipeline();
        end

        $display("Checked %0d pairs: %0d gated (%0d clipped), %0d zeroed, %0d passed through",
                 n_gate + n_zero + n_pass, n_gate, n_sat, n_zero, n_pass);
        $display("Over %0d register settings, with idle and back-pressure patterns on both sides",
                 n_settings);
        if (mismatches == 0 && expected_updates_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
